>>> hw/rtl/chd_pkg.sv
package chd_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_ORDER = 2'd0,  // load one symbol-order entry
    REQ_COUNT = 2'd1,  // load the code count of one length
    REQ_BIT   = 2'd2,  // next bit of the coded stream
    REQ_CLEAR = 2'd3   // zero all counts, drop the code in progress
  } chd_req_t;

  // Fixed field widths of the stream words.
  localparam int unsigned SYM_W = 9;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned VAL_W = 10;
  localparam int unsigned POS_W = 16;  // widest order-table address

  // What the code tracker hands to the output side for one item.
  typedef struct packed {
    logic             hit;  // this item finishes a code (match or error)
    logic             err;  // no symbol: code too long or position off the table
    logic [LEN_W-1:0] len;  // bits consumed, masked to the field width
    logic [POS_W-1:0] pos;  // order-table position of the symbol
  } chd_res_t;

endpackage

>>> hw/rtl/canonical_huffman_decoder_top.sv
// Canonical Huffman decoder. Input words carry a request kind in in_tuser:
// order loads fill the symbol-order table, count loads set how many codes
// each length has, code-bit words feed the stream one bit at a time, and a
// clear word zeroes all counts and drops any code in progress. A result word
// comes out when a code completes: the symbol and its length, or an error
// flag (symbol zero) when the code runs past MAX_CODE_LEN bits or lands
// beyond the order table. One word is taken every cycle unless a result is
// held in the lookup stage behind a stalled output. A result passes through
// the order-table read and then the output register. The count table is read
// one length ahead so each bit sees its count without a stall. Order entries
// must be loaded before a code can select them. No clearing pass after reset.
module canonical_huffman_decoder_top #(
  parameter int unsigned SYMBOL_BITS  = 9,
  parameter int unsigned ALPHABET     = 512,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry_index[8:0], entry_value[18:9], code_bit[19], zero pad
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // symbol[8:0], code_length[14:9], zero pad
  output logic [0:0]  out_tuser   // decode_error[0]
);

  localparam int unsigned AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  chd_pkg::chd_req_t            req;
  logic [chd_pkg::IDX_W-1:0]    entry_index;
  logic [chd_pkg::VAL_W-1:0]    entry_value;
  logic                         code_bit;
  logic                         in_acc;
  chd_pkg::chd_res_t            res;

  assign req         = chd_pkg::chd_req_t'(in_tuser);
  assign entry_index = in_tdata[8:0];
  assign entry_value = in_tdata[18:9];
  assign code_bit    = in_tdata[19];
  assign in_acc      = in_tvalid && in_tready;

  chd_core #(
    .ALPHABET     (ALPHABET),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .req         (req),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .code_bit    (code_bit),
    .res         (res)
  );

  // Symbol-order table
  logic [SYMBOL_BITS-1:0] sym_mem [ALPHABET];
  logic [SYMBOL_BITS-1:0] sym_rd_r;
  logic                   sym_we;

  assign sym_we = in_acc && (req == chd_pkg::REQ_ORDER) && (32'(entry_index) < ALPHABET);

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[AW'(entry_index)] <= SYMBOL_BITS'(32'(entry_value));
  end

  always_ff @(posedge clk) begin
    if (res.hit && !res.err) sym_rd_r <= sym_mem[AW'(res.pos)];
  end

  // Lookup stage (waits for the table read) then output register.
  logic                      a_valid_r, a_valid_nxt;
  logic                      a_err_r;
  logic [chd_pkg::LEN_W-1:0] a_len_r;
  logic                      a_adv;
  logic                      out_valid_r;
  logic [chd_pkg::SYM_W-1:0] out_sym_r;
  logic [chd_pkg::LEN_W-1:0] out_len_r;
  logic                      out_err_r;

  assign a_adv     = !out_valid_r || out_tready;
  assign in_tready = !a_valid_r || a_adv;

  always_comb begin
    priority if (res.hit) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (a_adv) out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res.hit) begin
      a_err_r <= res.err;
      a_len_r <= res.len;
    end
    if (a_valid_r && a_adv) begin
      out_sym_r <= a_err_r ? '0 : chd_pkg::SYM_W'(32'(sym_rd_r));
      out_len_r <= a_len_r;
      out_err_r <= a_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_sym_r};
  assign out_tuser  = out_err_r;

`ifndef SYNTH
  // Load and clear words never produce a result word.
  a_no_result_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (req != chd_pkg::REQ_BIT) |=> !a_valid_r)
    else $error("result produced by a non-bit word");

  // An error result always carries a zero symbol.
  a_err_zero_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[8:0] == '0)
    else $error("error result with nonzero symbol");

  // Table read data must hold while its lookup stage is stalled.
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_adv |=> $stable(sym_rd_r))
    else $error("order read data changed under a stall");

  // The tracker only finishes a code on an accepted bit word.
  a_hit_on_bit: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> in_acc && (req == chd_pkg::REQ_BIT))
    else $error("code finished without an accepted bit word");
`endif

endmodule

>>> hw/rtl/chd_core.sv
module chd_core #(
  parameter int unsigned ALPHABET     = 512,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  chd_pkg::chd_req_t            req,
  input  logic [chd_pkg::IDX_W-1:0]    entry_index,
  input  logic [chd_pkg::VAL_W-1:0]    entry_value,
  input  logic                         code_bit,
  output chd_pkg::chd_res_t            res
);

  localparam int unsigned CAW  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int unsigned LW   = CAW + 1;
  localparam int unsigned DW   = MAX_CODE_LEN;
  localparam int unsigned CMPW = (DW + 1 > chd_pkg::VAL_W) ? DW + 1 : chd_pkg::VAL_W;
  localparam int unsigned BW   = CAW + chd_pkg::VAL_W;

  // Running offset of the code above the first code of its length:
  // d' = 2*d + bit - count. It never goes negative on a stream that
  // keeps going, so no wide first-code register is needed.
  logic [DW-1:0]  dist_r, dist_nxt;
  logic [BW-1:0]  base_r, base_nxt;
  logic [CAW-1:0] cur_len_r, cur_len_nxt;

  // Count table: registered-read memory, valid bit per entry for clear.
  logic [chd_pkg::VAL_W-1:0] cnt_mem [MAX_CODE_LEN];
  logic [MAX_CODE_LEN-1:0]   cnt_vld_r, cnt_vld_nxt;
  logic [chd_pkg::VAL_W-1:0] cnt_q_r;

  logic                      cnt_we;
  logic [CAW-1:0]            cnt_waddr;
  logic [chd_pkg::VAL_W-1:0] cnt;
  logic [CMPW-1:0]           offs;
  logic [CMPW-1:0]           cnt_ext;
  logic                      match;
  logic                      too_long;
  logic [BW-1:0]             pos;
  logic                      pos_ok;
  logic [LW-1:0]             len;
  logic                      is_bit;

  assign is_bit    = step && (req == chd_pkg::REQ_BIT);
  assign cnt_we    = step && (req == chd_pkg::REQ_COUNT) &&
                     (32'(entry_index) < MAX_CODE_LEN);
  assign cnt_waddr = CAW'(entry_index);

  // cnt_q_r always holds the count of the current length.
  assign cnt     = cnt_vld_r[cur_len_r] ? cnt_q_r : '0;
  assign offs    = CMPW'({dist_r, code_bit});
  assign cnt_ext = CMPW'(cnt);
  assign match   = offs < cnt_ext;
  assign len     = LW'(cur_len_r) + LW'(1);
  assign too_long = (32'(cur_len_r) == MAX_CODE_LEN - 1);
  assign pos     = base_r + BW'(offs[chd_pkg::VAL_W-1:0]);
  assign pos_ok  = 32'(pos) < ALPHABET;

  always_comb begin
    res.hit = is_bit && (match || too_long);
    res.err = match ? !pos_ok : 1'b1;
    res.len = chd_pkg::LEN_W'(len);
    res.pos = chd_pkg::POS_W'(pos);
  end

  always_comb begin
    dist_nxt    = dist_r;
    base_nxt    = base_r;
    cur_len_nxt = cur_len_r;
    cnt_vld_nxt = cnt_vld_r;
    if (step) begin
      unique case (req)
        chd_pkg::REQ_ORDER: begin
        end
        chd_pkg::REQ_COUNT: begin
          if (cnt_we) cnt_vld_nxt[cnt_waddr] = 1'b1;
        end
        chd_pkg::REQ_CLEAR: begin
          cnt_vld_nxt = '0;
          dist_nxt    = '0;
          base_nxt    = '0;
          cur_len_nxt = '0;
        end
        chd_pkg::REQ_BIT: begin
          if (match || too_long) begin
            dist_nxt    = '0;
            base_nxt    = '0;
            cur_len_nxt = '0;
          end else begin
            dist_nxt    = DW'(offs - cnt_ext);
            base_nxt    = base_r + BW'(cnt);
            cur_len_nxt = cur_len_r + CAW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r    <= '0;
      base_r    <= '0;
      cur_len_r <= '0;
      cnt_vld_r <= '0;
    end else begin
      dist_r    <= dist_nxt;
      base_r    <= base_nxt;
      cur_len_r <= cur_len_nxt;
      cnt_vld_r <= cnt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= entry_value;
  end

  // Read ahead at the length the next item will see; a same-cycle load
  // of that entry is forwarded.
  always_ff @(posedge clk) begin
    if (cnt_we && (cnt_waddr == cur_len_nxt)) begin
      cnt_q_r <= entry_value;
    end else begin
      cnt_q_r <= cnt_mem[cur_len_nxt];
    end
  end

endmodule
